@@ rtl/pdce_pkg.sv @@
// Package: shared constants, types and encoding helpers for the PLL divider config encoder.
package pdce_pkg;

  localparam int CAL_RATIO_DEF   = 2;
  localparam int CAL_MS          = 4400;
  localparam int FMS_W           = 19;
  localparam logic [27:0] REF_RESET  = 28'd40000000;
  localparam logic [FMS_W-1:0] FMS_RESET = 19'd40000;
  localparam logic [28:0] MS_ROUND   = 29'd999;
  localparam logic [26:0] RECIP_125  = 27'd68719477;
  localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;
  localparam logic [23:0] TICKS_MAX  = 24'hFFFFFF;
  localparam logic [13:0] B_MAX      = 14'd8191;
  localparam logic [6:0]  A_MAX      = 7'd63;
  localparam logic [5:0]  P_16       = 6'd16;
  localparam logic [5:0]  P_32       = 6'd32;
  localparam logic [2:0]  PCODE_16   = 3'h5;
  localparam logic [2:0]  PCODE_OTHER = 3'h6;

  typedef struct packed {
    logic        request_ok;
    logic [5:0]  a_code;
    logic [13:0] b_code;
    logic [13:0] r_code;
    logic [2:0]  prescaler_code;
    logic [2:0]  vco_div_code;
    logic        vco_bypass;
    logic [7:0]  div_one_code;
    logic        div_one_bypass;
    logic [7:0]  div_two_code;
    logic        div_two_bypass;
  } pdce_fields_t;

  function automatic logic [8:0] enc_div(input logic [5:0] d);
    logic [5:0] dd;
    logic [5:0] m;
    logic [5:0] n;
    dd = d - 6'd2;
    n  = dd >> 1;
    m  = n + {5'd0, dd[0]};
    if (d == 6'd0) begin
      enc_div = {8'd0, 1'b1};
    end else begin
      enc_div = {m[3:0], n[3:0], 1'b0};
    end
  endfunction

endpackage

@@ rtl/pdce_front.sv @@
// Front end: range checks, divider normalisation and field encoding of each request.
module pdce_front #(
  parameter int CAL_RATIO = pdce_pkg::CAL_RATIO_DEF,
  parameter int NUM_W = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [6:0]            in_a_count,
  input  logic [13:0]           in_b_count,
  input  logic [13:0]           in_r_count,
  input  logic [5:0]            in_prescaler,
  input  logic [2:0]            in_vco_divide,
  input  logic [5:0]            in_chan_div_one,
  input  logic [5:0]            in_chan_div_two,
  input  logic                  in_external_clock,
  input  logic                  q_full,
  output logic                  q_push,
  output pdce_pkg::pdce_fields_t q_fields,
  output logic [NUM_W-1:0]      q_num
);
  import pdce_pkg::*;

  localparam int CAL_K = CAL_MS * CAL_RATIO;

  logic         valid_r;
  pdce_fields_t fld_r, fld_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [13:0]  r_n;
  logic [2:0]   dv;
  logic [5:0]   d1, d2, s1, s2;
  logic [8:0]   e1, e2;
  logic         ok;

  assign in_stall = valid_r && q_full;
  assign q_push   = valid_r && !q_full;
  assign q_fields = fld_r;
  assign q_num    = num_r;

  always_comb begin
    ok = 1'b1;
    if (in_a_count > {7'd0, in_b_count} || in_a_count > A_MAX) ok = 1'b0;
    if (in_prescaler != P_16 && in_prescaler != P_32) ok = 1'b0;
    if (in_b_count == 14'd0 || in_b_count > B_MAX) ok = 1'b0;
    if (in_r_count == 14'd0) ok = 1'b0;
    r_n = (in_r_count == 14'd1) ? 14'd0 : in_r_count;
    dv  = (in_vco_divide == 3'd1) ? 3'd0 : in_vco_divide;
    d1  = (in_chan_div_one == 6'd1) ? 6'd0 : in_chan_div_one;
    d2  = (in_chan_div_two == 6'd1) ? 6'd0 : in_chan_div_two;
    s1  = d1;
    s2  = d2;
    if (d1 == 6'd0 && d2 != 6'd0) begin
      s1 = d2;
      s2 = 6'd0;
    end else if (d1 != 6'd0 && d2 != 6'd0 && d1[0] && !d2[0]) begin
      s1 = d2;
      s2 = d1;
    end
    e1 = enc_div(s1);
    e2 = enc_div(s2);
    fld_nxt.request_ok     = ok;
    fld_nxt.a_code         = in_a_count[5:0];
    fld_nxt.b_code         = in_b_count;
    fld_nxt.r_code         = r_n;
    fld_nxt.prescaler_code = (in_prescaler == P_16) ? PCODE_16 : PCODE_OTHER;
    if (dv == 3'd0 && in_external_clock) begin
      fld_nxt.vco_div_code = 3'd0;
      fld_nxt.vco_bypass   = 1'b1;
    end else begin
      if (dv < 3'd2 || dv > 3'd6) begin
        fld_nxt.vco_div_code = 3'd0;
      end else begin
        fld_nxt.vco_div_code = dv - 3'd2;
      end
      fld_nxt.vco_bypass = 1'b0;
    end
    fld_nxt.div_one_code   = e1[8:1];
    fld_nxt.div_one_bypass = e1[0];
    fld_nxt.div_two_code   = e2[8:1];
    fld_nxt.div_two_bypass = e2[0];
    num_nxt = NUM_W'(r_n) * NUM_W'(CAL_K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      fld_r <= fld_nxt;
      num_r <= num_nxt;
    end
  end

endmodule

@@ rtl/pdce_queue.sv @@
// Two-entry queue between front end and calibration back end.
module pdce_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [0:1];
  logic         wptr_r, rptr_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

endmodule

@@ rtl/pdce_back.sv @@
// Back end: calibration wait via pipelined divider, tick rounding and result register.
module pdce_back #(
  parameter int NUM_W = 28
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [27:0]            cfg_ref_freq_hz,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  pdce_pkg::pdce_fields_t q_fields,
  input  logic [NUM_W-1:0]       q_num,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pdce_pkg::pdce_fields_t out_fields,
  output logic [23:0]            out_ticks
);
  import pdce_pkg::*;

  localparam int DIV_W = NUM_W + 1;

  logic [27:0]      ref_r;
  logic [FMS_W-1:0] fms_r, fms_nxt;
  logic [28:0]      ref_rnd;
  logic [52:0]      fms_prod;
  logic             adv;

  logic             v_r   [0:DIV_W];
  pdce_fields_t     fld_r [0:DIV_W];
  logic [FMS_W-1:0] rem_r [0:DIV_W];
  logic [DIV_W-1:0] wq_r  [0:DIV_W];

  logic             mv_r;
  pdce_fields_t     mfld_r;
  logic [63:0]      prod_r;
  logic [31:0]      x_nxt;
  logic [28:0]      t10;
  logic [29:0]      tk;

  logic             out_valid_r;
  pdce_fields_t     out_fields_r;
  logic [23:0]      out_ticks_r;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || !out_stall;
  assign q_pop      = adv && !q_empty;
  assign out_valid  = out_valid_r;
  assign out_fields = out_fields_r;
  assign out_ticks  = out_ticks_r;

  always_comb begin
    ref_rnd  = {1'b0, ref_r} + MS_ROUND;
    fms_prod = 53'(ref_rnd[28:3]) * 53'(RECIP_125);
    fms_nxt  = FMS_W'(fms_prod[52:33]);
    if (fms_nxt == '0) fms_nxt = FMS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
      fms_r <= FMS_RESET;
    end else begin
      if (cfg_valid) ref_r <= cfg_ref_freq_hz;
      fms_r <= fms_nxt;
    end
  end

  // load: round numerator up so the floor quotient is the ceiling
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fld_r[0] <= q_fields;
      rem_r[0] <= '0;
      wq_r[0]  <= DIV_W'(q_num) + DIV_W'(fms_r) - DIV_W'(1);
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [FMS_W:0]   t;
    logic             ge;
    logic [FMS_W-1:0] rem_nxt;
    always_comb begin
      t       = {rem_r[k], wq_r[k][DIV_W-1]};
      ge      = (t >= {1'b0, fms_r});
      rem_nxt = ge ? FMS_W'(t - {1'b0, fms_r}) : t[FMS_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        fld_r[k+1] <= fld_r[k];
        rem_r[k+1] <= rem_nxt;
        wq_r[k+1]  <= {wq_r[k][DIV_W-2:0], ge};
      end
    end
  end

  assign x_nxt = 32'(wq_r[DIV_W]) + 32'd9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= v_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mfld_r <= fld_r[DIV_W];
      prod_r <= 64'(x_nxt) * 64'(RECIP_10);
    end
  end

  assign t10 = prod_r[63:35];
  assign tk  = {1'b0, t10} + 30'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fields_r <= mfld_r;
      out_ticks_r  <= (tk > 30'(TICKS_MAX)) ? TICKS_MAX : tk[23:0];
    end
  end

endmodule

@@ rtl/pll_divider_config_encoder_unit.sv @@
// Top level of the PLL divider configuration encoder.
// One request per cycle is accepted while in_stall is low; one result beat leaves per
// request, in order. out_valid rises after the front register, the queue, the load stage,
// the 29 one-bit stages of the calibration divider at the default CAL_RATIO of 2, and the
// multiply and output registers. A stalled result holds the whole back end. ref_freq_hz
// is taken in one cycle and its ms rounding is ready on the next.
module pll_divider_config_encoder_unit #(
  parameter int CAL_RATIO = pdce_pkg::CAL_RATIO_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_ref_freq_hz,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_a_count,
  input  logic [13:0] in_b_count,
  input  logic [13:0] in_r_count,
  input  logic [5:0]  in_prescaler,
  input  logic [2:0]  in_vco_divide,
  input  logic [5:0]  in_chan_div_one,
  input  logic [5:0]  in_chan_div_two,
  input  logic        in_external_clock,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_request_ok,
  output logic [5:0]  out_a_code,
  output logic [13:0] out_b_code,
  output logic [13:0] out_r_code,
  output logic [2:0]  out_prescaler_code,
  output logic [2:0]  out_vco_div_code,
  output logic        out_vco_bypass,
  output logic [7:0]  out_div_one_code,
  output logic        out_div_one_bypass,
  output logic [7:0]  out_div_two_code,
  output logic        out_div_two_bypass,
  output logic [23:0] out_calib_wait_ticks
);
  import pdce_pkg::*;

  localparam int NUM_W = 14 + $clog2(CAL_MS * CAL_RATIO + 1);
  localparam int QW    = $bits(pdce_fields_t) + NUM_W;

  logic             push, full, pop, empty;
  pdce_fields_t     f_fields, b_fields, o_fields;
  logic [NUM_W-1:0] f_num, b_num;
  logic [QW-1:0]    q_rdata;

  pdce_front #(.CAL_RATIO(CAL_RATIO), .NUM_W(NUM_W)) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_a_count, .in_b_count, .in_r_count, .in_prescaler, .in_vco_divide,
    .in_chan_div_one, .in_chan_div_two, .in_external_clock,
    .q_full(full), .q_push(push), .q_fields(f_fields), .q_num(f_num)
  );

  pdce_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push, .wdata({f_fields, f_num}), .full,
    .pop, .empty, .rdata(q_rdata)
  );

  assign b_fields = q_rdata[QW-1:NUM_W];
  assign b_num    = q_rdata[NUM_W-1:0];

  pdce_back #(.NUM_W(NUM_W)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_ref_freq_hz,
    .q_empty(empty), .q_pop(pop), .q_fields(b_fields), .q_num(b_num),
    .out_valid, .out_stall, .out_fields(o_fields), .out_ticks(out_calib_wait_ticks)
  );

  assign out_request_ok     = o_fields.request_ok;
  assign out_a_code         = o_fields.a_code;
  assign out_b_code         = o_fields.b_code;
  assign out_r_code         = o_fields.r_code;
  assign out_prescaler_code = o_fields.prescaler_code;
  assign out_vco_div_code   = o_fields.vco_div_code;
  assign out_vco_bypass     = o_fields.vco_bypass;
  assign out_div_one_code   = o_fields.div_one_code;
  assign out_div_one_bypass = o_fields.div_one_bypass;
  assign out_div_two_code   = o_fields.div_two_code;
  assign out_div_two_bypass = o_fields.div_two_bypass;

endmodule

@@ tb/tb_pll_divider_config_encoder_unit.sv @@
// Testbench for the PLL divider config encoder: random requests checked against a predictor.
module tb_pll_divider_config_encoder_unit;
  import pdce_pkg::*;

  typedef struct {
    logic [6:0]  a;
    logic [13:0] b;
    logic [13:0] r;
    logic [5:0]  p;
    logic [2:0]  vdiv;
    logic [5:0]  d1;
    logic [5:0]  d2;
    logic        ext;
  } pll_req_t;

  typedef struct {
    logic        ok;
    logic [5:0]  a_code;
    logic [13:0] b_code;
    logic [13:0] r_code;
    logic [2:0]  p_code;
    logic [2:0]  vco_code;
    logic        vco_byp;
    logic [7:0]  d1_code;
    logic        d1_byp;
    logic [7:0]  d2_code;
    logic        d2_byp;
    logic [23:0] ticks;
  } pll_enc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [27:0] cfg_ref_freq_hz = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [6:0]  in_a_count = '0;
  logic [13:0] in_b_count = '0;
  logic [13:0] in_r_count = '0;
  logic [5:0]  in_prescaler = '0;
  logic [2:0]  in_vco_divide = '0;
  logic [5:0]  in_chan_div_one = '0;
  logic [5:0]  in_chan_div_two = '0;
  logic        in_external_clock = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_request_ok;
  logic [5:0]  out_a_code;
  logic [13:0] out_b_code;
  logic [13:0] out_r_code;
  logic [2:0]  out_prescaler_code;
  logic [2:0]  out_vco_div_code;
  logic        out_vco_bypass;
  logic [7:0]  out_div_one_code;
  logic        out_div_one_bypass;
  logic [7:0]  out_div_two_code;
  logic        out_div_two_bypass;
  logic [23:0] out_calib_wait_ticks;

  pll_divider_config_encoder_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pll_req_t    req_pending[$];
  pll_enc_t    enc_expected[$];
  pll_req_t    req_cur;
  logic [27:0] ref_hz = REF_RESET;
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          send_gap = 0;
  bit          send_busy = 1'b0;
  bit          stall_busy = 1'b0;

  function automatic logic [8:0] div_byte(logic [5:0] d);
    logic [5:0] rest;
    logic [5:0] m;
    logic [5:0] n;
    if (d == 6'd0) return {8'd0, 1'b1};
    rest = d - 6'd2;
    n = rest / 2;
    m = rest / 2 + rest % 2;
    return {m[3:0], n[3:0], 1'b0};
  endfunction

  function automatic pll_enc_t encode_request(pll_req_t q, logic [27:0] fref);
    pll_enc_t   e;
    logic [13:0] r;
    logic [2:0]  dv;
    logic [5:0]  d1;
    logic [5:0]  d2;
    logic [5:0]  t;
    longint unsigned fms;
    longint unsigned wait_ms;
    longint unsigned wait_t;
    e.ok = !(q.a > q.b || q.a > 7'd63 || (q.p != 6'd16 && q.p != 6'd32) ||
             q.b == 0 || q.b > 14'd8191 || q.r == 0);
    r  = (q.r == 14'd1) ? 14'd0 : q.r;
    dv = (q.vdiv == 3'd1) ? 3'd0 : q.vdiv;
    d1 = (q.d1 == 6'd1) ? 6'd0 : q.d1;
    d2 = (q.d2 == 6'd1) ? 6'd0 : q.d2;
    if (d1 == 0 && d2 != 0) begin
      d1 = d2;
      d2 = 6'd0;
    end else if (d1 != 0 && d2 != 0 && d1[0] && !d2[0]) begin
      t = d1;
      d1 = d2;
      d2 = t;
    end
    e.a_code = q.a[5:0];
    e.b_code = q.b;
    e.r_code = r;
    e.p_code = (q.p == 6'd16) ? PCODE_16 : PCODE_OTHER;
    if (dv == 0 && q.ext) begin
      e.vco_code = 3'd0;
      e.vco_byp = 1'b1;
    end else begin
      if (dv < 2 || dv > 6) dv = 3'd2;
      e.vco_code = dv - 3'd2;
      e.vco_byp = 1'b0;
    end
    {e.d1_code, e.d1_byp} = div_byte(d1);
    {e.d2_code, e.d2_byp} = div_byte(d2);
    fms = (fref + 999) / 1000;
    if (fms == 0) fms = 1;
    wait_ms = (64'd4400 * r * CAL_RATIO_DEF + fms - 1) / fms;
    wait_t = (wait_ms + 9) / 10 + 1;
    e.ticks = (wait_t > 64'hFFFFFF) ? TICKS_MAX : wait_t[23:0];
    return e;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        enc_expected.push_back(encode_request(req_cur, ref_hz));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          req_cur = req_pending.pop_front();
          in_a_count <= req_cur.a;
          in_b_count <= req_cur.b;
          in_r_count <= req_cur.r;
          in_prescaler <= req_cur.p;
          in_vco_divide <= req_cur.vdiv;
          in_chan_div_one <= req_cur.d1;
          in_chan_div_two <= req_cur.d2;
          in_external_clock <= req_cur.ext;
          in_valid <= 1'b1;
          send_gap = send_busy ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    pll_enc_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (enc_expected.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        w = enc_expected.pop_front();
        n_checked++;
        check_field("request_ok", w.ok, out_request_ok);
        check_field("a_code", w.a_code, out_a_code);
        check_field("b_code", w.b_code, out_b_code);
        check_field("r_code", w.r_code, out_r_code);
        check_field("prescaler_code", w.p_code, out_prescaler_code);
        check_field("vco_div_code", w.vco_code, out_vco_div_code);
        check_field("vco_bypass", w.vco_byp, out_vco_bypass);
        check_field("div_one_code", w.d1_code, out_div_one_code);
        check_field("div_one_bypass", w.d1_byp, out_div_one_bypass);
        check_field("div_two_code", w.d2_code, out_div_two_code);
        check_field("div_two_bypass", w.d2_byp, out_div_two_bypass);
        check_field("calib_wait_ticks", w.ticks, out_calib_wait_ticks);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && stall_busy) begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic pll_req_t random_request(bit well_formed);
    pll_req_t q;
    q.b    = well_formed ? 14'($urandom_range(1, 8191)) : 14'($urandom);
    q.a    = well_formed ? 7'($urandom_range(0, (q.b < 63) ? q.b : 63)) : 7'($urandom);
    q.r    = well_formed ? 14'($urandom_range(1, 16383)) : 14'($urandom);
    q.p    = well_formed ? ($urandom_range(0, 1) ? 6'd16 : 6'd32) : 6'($urandom);
    q.vdiv = 3'($urandom);
    q.d1   = 6'($urandom_range(0, 32));
    q.d2   = 6'($urandom_range(0, 32));
    q.ext  = 1'($urandom);
    return q;
  endfunction

  task automatic add_req(logic [6:0] a, logic [13:0] b, logic [13:0] r, logic [5:0] p,
                         logic [2:0] v, logic [5:0] d1, logic [5:0] d2, logic ext);
    pll_req_t q;
    q.a = a; q.b = b; q.r = r; q.p = p; q.vdiv = v; q.d1 = d1; q.d2 = d2; q.ext = ext;
    req_pending.push_back(q);
  endtask

  task automatic wait_idle();
    while (req_pending.size() > 0 || in_valid || enc_expected.size() > 0) @(posedge clk);
  endtask

  task automatic write_ref(logic [27:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_ref_freq_hz <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ref_hz = v;
    repeat (3) @(posedge clk);
  endtask

  initial begin
    logic [27:0] refs[5];
    refs = '{28'd1000, 28'd250000000, 28'd0, 28'hFFFFFFF, 28'd0};
    refs[4] = 28'($urandom_range(1000, 250000000));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed corners at the reset frequency
    add_req(7'd0, 14'd1, 14'd1, 6'd16, 3'd0, 6'd0, 6'd0, 1'b1);
    add_req(7'd63, 14'd8191, 14'd16383, 6'd32, 3'd6, 6'd32, 6'd32, 1'b0);
    add_req(7'd127, 14'd16383, 14'd0, 6'd63, 3'd7, 6'd1, 6'd1, 1'b0);
    add_req(7'd10, 14'd5, 14'd2, 6'd16, 3'd1, 6'd1, 6'd5, 1'b1);
    add_req(7'd0, 14'd0, 14'd3, 6'd0, 3'd1, 6'd7, 6'd4, 1'b0);
    add_req(7'd64, 14'd8192, 14'd100, 6'd17, 3'd2, 6'd7, 6'd0, 1'b1);
    add_req(7'd5, 14'd100, 14'd16383, 6'd32, 3'd0, 6'd2, 6'd3, 1'b0);
    add_req(7'd8, 14'd8, 14'd1, 6'd16, 3'd3, 6'd9, 6'd1, 1'b1);
    add_req(7'd1, 14'd2, 14'd4000, 6'd32, 3'd4, 6'd0, 6'd31, 1'b0);
    add_req(7'd2, 14'd3, 14'd5, 6'd16, 3'd5, 6'd3, 6'd2, 1'b1);
    add_req(7'd63, 14'd62, 14'd9, 6'd32, 3'd7, 6'd32, 6'd17, 1'b1);
    add_req(7'h55, 14'h2AAA, 14'h1555, 6'h2A, 3'd5, 6'd21, 6'd10, 1'b0);
    wait_idle();
    write_ref(28'd40000000);
    for (int ph = 0; ph < 5; ph++) begin
      send_busy = (ph != 2);
      stall_busy = (ph != 3);
      write_ref(refs[ph]);
      for (int i = 0; i < 180; i++) req_pending.push_back(random_request($urandom_range(0, 9) < 7));
      wait_idle();
    end
    wait_idle();
    repeat (60) @(posedge clk);
    $display("Sent %0d requests, checked %0d results over six reference frequencies,",
             n_sent, n_checked);
    $display("including zero and full-scale frequency, with random idling on both sides.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
